### design/geometric_frame_remap_unit_macros.svh
// Assertion macros for the frame remap RTL.
`ifndef GEOMETRIC_FRAME_REMAP_UNIT_MACROS_SVH
`define GEOMETRIC_FRAME_REMAP_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define GFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define GFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define GFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### design/gfr_pkg.sv
package gfr_pkg;

    // Frame geometry default
    localparam int GFR_SIDE = 256;

    // Field widths
    localparam int COORD_W = 8;
    localparam int COLOR_W = 8;
    localparam int PIX_W   = 3 * COLOR_W;
    localparam int MODE_W  = 4;
    localparam int QUAD_W  = 2;
    localparam int SHRF_W  = 3;
    localparam int SHUF_W  = 8;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Remap modes
    localparam logic [MODE_W-1:0] MODE_VFLIP    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_HFLIP    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_ROT90    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ROT180   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ROT270   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MIR_LEFT = 4'd5;
    localparam logic [MODE_W-1:0] MODE_MIR_RGHT = 4'd6;
    localparam logic [MODE_W-1:0] MODE_MIR_UP   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_MIR_DOWN = 4'd8;
    localparam logic [MODE_W-1:0] MODE_ENLARGE  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_SHRINK   = 4'd10;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE  = 4'd11;

    // Register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_ENL_Q   = 2'd1;
    localparam logic [1:0] REG_SHRINK  = 2'd2;
    localparam logic [1:0] REG_SHUFFLE = 2'd3;

    // Register reset values
    localparam logic [MODE_W-1:0] RST_MODE    = MODE_VFLIP;
    localparam logic [QUAD_W-1:0] RST_ENL_Q   = 2'd0;
    localparam logic [SHRF_W-1:0] RST_SHRINK  = 3'd2;
    localparam logic [SHUF_W-1:0] RST_SHUFFLE = 8'd228;

    // Shrink factor limits
    localparam logic [SHRF_W-1:0] SHRINK_MIN = 3'd2;
    localparam logic [SHRF_W-1:0] SHRINK_MAX = 3'd4;

    localparam logic [PIX_W-1:0] PIX_WHITE = {PIX_W{1'b1}};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [QUAD_W-1:0] enl_q;
        logic [SHRF_W-1:0] shrink;
        logic [SHUF_W-1:0] shuffle;
    } t_cfg;

endpackage

### design/gfr_ram.sv
module gfr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one entry per enabled cycle; read data is registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/gfr_cfg_regs.sv
module gfr_cfg_regs import gfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [MODE_W-1:0] r_mode;
    logic [QUAD_W-1:0] r_enl_q;
    logic [SHRF_W-1:0] r_shrink;
    logic [SHUF_W-1:0] r_shuffle;
    logic [1:0]        w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Update the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= RST_MODE;
            r_enl_q   <= RST_ENL_Q;
            r_shrink  <= RST_SHRINK;
            r_shuffle <= RST_SHUFFLE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:    r_mode    <= pwdata[MODE_W-1:0];
                REG_ENL_Q:   r_enl_q   <= pwdata[QUAD_W-1:0];
                REG_SHRINK:  r_shrink  <= pwdata[SHRF_W-1:0];
                REG_SHUFFLE: r_shuffle <= pwdata[SHUF_W-1:0];
            endcase
        end
    end

    // Read back zero-extended register values
    always_comb begin
        unique case (w_idx)
            REG_MODE:    prdata = APB_DW'(r_mode);
            REG_ENL_Q:   prdata = APB_DW'(r_enl_q);
            REG_SHRINK:  prdata = APB_DW'(r_shrink);
            REG_SHUFFLE: prdata = APB_DW'(r_shuffle);
        endcase
    end

    assign o_cfg = '{mode: r_mode, enl_q: r_enl_q, shrink: r_shrink, shuffle: r_shuffle};

endmodule

### design/gfr_remap.sv
module gfr_remap import gfr_pkg::*; #(
    parameter int SIDE = GFR_SIDE
) (
    input  t_cfg                      i_cfg,
    input  logic                      i_op,
    input  logic [COORD_W-1:0]        i_row,
    input  logic [COORD_W-1:0]        i_col,
    output logic [$clog2(SIDE)-1:0]   o_src_row,
    output logic [$clog2(SIDE)-1:0]   o_src_col,
    output logic                      o_white
);

    localparam int CW = $clog2(SIDE);
    localparam int NCOORD = 1 << COORD_W;
    localparam logic [CW-1:0] M    = CW'(SIDE - 1);
    localparam logic [CW-1:0] H    = CW'(SIDE / 2);
    localparam logic [CW-1:0] EXT2 = CW'((SIDE + 1) / 2);
    localparam logic [CW-1:0] EXT3 = CW'((SIDE + 2) / 3);
    localparam logic [CW-1:0] EXT4 = CW'((SIDE + 3) / 4);

    logic [CW-1:0] w_mod_tab [NCOORD];
    logic [CW-1:0] w_r, w_c, w_mr, w_mc;
    logic [CW-1:0] w_row, w_col;
    logic [CW+1:0] w_rf, w_cf;
    logic [CW-1:0] w_ext;
    logic          w_rh, w_ch, w_out_area;
    logic [1:0]    w_sq;
    logic [1:0]    w_k;

    // Reduce incoming coordinates modulo the frame side
    for (genvar g = 0; g < NCOORD; g++) begin : g_mod
        assign w_mod_tab[g] = CW'(g % SIDE);
    end

    assign w_r  = w_mod_tab[i_row];
    assign w_c  = w_mod_tab[i_col];
    assign w_mr = M - w_r;
    assign w_mc = M - w_c;
    assign w_rh = (w_r >= H);
    assign w_ch = (w_c >= H);
    assign w_k  = {w_rh, w_ch};
    assign w_sq = i_cfg.shuffle[2*w_k +: 2];

    // Clamp shrink factor and scale coordinates by it
    always_comb begin
        if (i_cfg.shrink <= SHRINK_MIN) begin
            w_rf  = {1'b0, w_r, 1'b0};
            w_cf  = {1'b0, w_c, 1'b0};
            w_ext = EXT2;
        end else if (i_cfg.shrink >= SHRINK_MAX) begin
            w_rf  = {w_r, 2'b00};
            w_cf  = {w_c, 2'b00};
            w_ext = EXT4;
        end else begin
            w_rf  = {1'b0, w_r, 1'b0} + (CW+2)'(w_r);
            w_cf  = {1'b0, w_c, 1'b0} + (CW+2)'(w_c);
            w_ext = EXT3;
        end
    end

    assign w_out_area = (w_r >= w_ext) || (w_c >= w_ext);

    // Select source coordinates for the configured mode
    always_comb begin
        w_row = w_r;
        w_col = w_c;
        unique case (i_cfg.mode)
            MODE_VFLIP: w_row = w_mr;
            MODE_HFLIP: w_col = w_mc;
            MODE_ROT90: begin
                w_row = w_mc;
                w_col = w_r;
            end
            MODE_ROT180: begin
                w_row = w_mr;
                w_col = w_mc;
            end
            MODE_ROT270: begin
                w_row = w_c;
                w_col = w_mr;
            end
            MODE_MIR_LEFT: w_col = (w_c < H) ? w_c : w_mc;
            MODE_MIR_RGHT: w_col = (w_c < H) ? w_mc : w_c;
            MODE_MIR_UP:   w_row = (w_r < H) ? w_r : w_mr;
            MODE_MIR_DOWN: w_row = (w_r >= H) ? w_r : w_mr;
            MODE_ENLARGE: begin
                w_row = (i_cfg.enl_q[1] ? H : '0) + (w_r >> 1);
                w_col = (i_cfg.enl_q[0] ? H : '0) + (w_c >> 1);
            end
            MODE_SHRINK: begin
                w_row = w_rf[CW-1:0];
                w_col = w_cf[CW-1:0];
            end
            MODE_SHUFFLE: begin
                w_row = (w_sq[1] ? H : '0) + (w_rh ? w_r - H : w_r);
                w_col = (w_sq[0] ? H : '0) + (w_ch ? w_c - H : w_c);
            end
            default: begin
                w_row = w_r;
                w_col = w_c;
            end
        endcase
    end

    // Writes land at the plain coordinates
    assign o_src_row = (i_op == OP_READ) ? w_row : w_r;
    assign o_src_col = (i_op == OP_READ) ? w_col : w_c;
    assign o_white   = (i_op == OP_READ) && (i_cfg.mode == MODE_SHRINK) && w_out_area;

endmodule

### design/geometric_frame_remap_unit.sv
// Frame remapper for a square SIDE x SIDE RGB image held in one single-port
// frame memory. Each item makes exactly one memory access: a write item stores
// its pixel at (row, col), a read item fetches the pixel that the configured
// flip, rotation, mirror, enlarge, shrink or shuffle maps onto (row, col) and
// returns it as one result (white outside the shrunk area). The block takes one
// item per clock while the output is not stalled; the single memory port, used
// once per item, sets that rate, and because writes and reads reach the port
// in arrival order a read always sees every earlier write. A read result
// passes the coordinate remap, memory read and output registers after its
// item is accepted. Frame entries are undefined after reset and there is no
// clearing pass: read only pixels that were written. Configuration registers
// may be written only while no item is in flight.
`include "geometric_frame_remap_unit_macros.svh"

module geometric_frame_remap_unit import gfr_pkg::*; #(
    parameter int SIDE = GFR_SIDE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COLOR_W-1:0] i_in_red,
    input  logic [COLOR_W-1:0] i_in_green,
    input  logic [COLOR_W-1:0] i_in_blue,
    // Result item channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COLOR_W-1:0] o_out_red,
    output logic [COLOR_W-1:0] o_out_green,
    output logic [COLOR_W-1:0] o_out_blue,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int CW    = $clog2(SIDE);
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);

    t_cfg             w_cfg;
    logic [CW-1:0]    w_src_row, w_src_col;
    logic             w_white;
    logic             w_e_out, w_e3, w_e1, w_in_acc;
    logic [AW-1:0]    w_addr;
    logic [PIX_W-1:0] w_rdata;

    logic             r_s1_valid;
    logic             r_s1_op;
    logic [CW-1:0]    r_s1_row, r_s1_col;
    logic             r_s1_white;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s3_valid;
    logic             r_s3_white;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;

    gfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gfr_remap #(.SIDE(SIDE)) u_remap (
        .i_cfg     (w_cfg),
        .i_op      (i_op),
        .i_row     (i_row),
        .i_col     (i_col),
        .o_src_row (w_src_row),
        .o_src_col (w_src_col),
        .o_white   (w_white)
    );

    // Advance each stage when the one after it is empty or moving
    assign w_e_out    = !r_out_valid || !i_out_stall;
    assign w_e3       = !r_s3_valid || w_e_out;
    assign w_e1       = !r_s1_valid || w_e3;
    assign w_in_acc   = i_in_valid && w_e1;
    assign o_in_stall = !w_e1;

    // Capture the remapped source location of an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_e1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_op    <= i_op;
            r_s1_row   <= w_src_row;
            r_s1_col   <= w_src_col;
            r_s1_white <= w_white;
            r_s1_pix   <= {i_in_red, i_in_green, i_in_blue};
        end
    end

    // Access the frame memory once per item
    assign w_addr = AW'(r_s1_row) * AW'(SIDE) + AW'(r_s1_col);

    gfr_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
        .i_clk   (i_clk),
        .i_en    (r_s1_valid && w_e3),
        .i_we    (r_s1_op == OP_WRITE),
        .i_addr  (w_addr),
        .i_wdata (r_s1_pix),
        .o_rdata (w_rdata)
    );

    // Track the read data now held in the memory output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_e3) begin
            r_s3_valid <= r_s1_valid && (r_s1_op == OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e3) begin
            r_s3_white <= r_s1_white;
        end
    end

    // Hold the result until taken; fill white outside the shrunk area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_e_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_out && r_s3_valid) begin
            r_out_pix <= r_s3_white ? PIX_WHITE : w_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix[3*COLOR_W-1:2*COLOR_W];
    assign o_out_green = r_out_pix[2*COLOR_W-1:COLOR_W];
    assign o_out_blue  = r_out_pix[COLOR_W-1:0];

    // Checks
    `GFR_ASSERT(a_write_no_result, i_clk, i_rst_n, r_s1_valid && w_e3 && (r_s1_op == OP_WRITE) |=> !r_s3_valid, "write item produced a result")
    `GFR_ASSERT(a_out_from_read, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_s3_valid), "result appeared without read data")
    `GFR_ASSERT_NEVER(a_white_on_write, i_clk, i_rst_n, r_s1_valid && r_s1_white && (r_s1_op == OP_WRITE), "white fill flagged on a write")
    `GFR_ASSERT_NEVER(a_stall_when_empty, i_clk, i_rst_n, o_in_stall && !r_s1_valid, "input stalled with empty first stage")

endmodule
